// ===== hdl/cltc_pkg.sv =====
package cltc_pkg;

   typedef enum logic [2:0] {
      KIND_WORD   = 3'd0,
      KIND_OPTION = 3'd1,
      KIND_NUMBER = 3'd2,
      KIND_ANGLE  = 3'd3,
      KIND_COMMA  = 3'd4,
      KIND_TEXT   = 3'd5,
      KIND_BAD    = 3'd6,
      KIND_EMPTY  = 3'd7
   } kind_type;

   // candidate class flags of the piece being collected
   localparam int FLAG_W           = 7;
   localparam int FLAG_ALL_LOWER   = 0;
   localparam int FLAG_TAIL_LOWER  = 1;
   localparam int FLAG_MID_LOWER   = 2;
   localparam int FLAG_FIRST_LT    = 3;
   localparam int FLAG_NUM_OK      = 4;
   localparam int FLAG_FIRST_DASH  = 5;
   localparam int FLAG_FIRST_QUOTE = 6;
   typedef logic [FLAG_W-1:0] flags_type;

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_QUOTE   = 8'h22;
   localparam logic [7:0] CHAR_LT      = 8'h3C;
   localparam logic [7:0] CHAR_GT      = 8'h3E;
   localparam logic [7:0] CHAR_DASH    = 8'h2D;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   // number accumulator saturates at 2^32
   localparam int              ACC_W     = 33;
   localparam logic [ACC_W-1:0] ACC_CAP   = 33'h1_0000_0000;
   localparam logic [ACC_W-1:0] LIMIT_POS = 33'h0_7FFF_FFFF;
   localparam logic [ACC_W-1:0] LIMIT_NEG = 33'h0_8000_0000;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  start;
      logic [8:0]  length;
      logic [31:0] value;
      logic        last;
   } result_type;

   // zero, one or two results produced by one byte
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

endpackage

// ===== hdl/cltc_classify.sv =====
module cltc_classify
   import cltc_pkg::*;
(
   input  flags_type        flags,
   input  logic             len_one,
   input  logic             len_two_up,
   input  logic             len_three_up,
   input  logic [7:0]       last_char,
   input  logic [ACC_W-1:0] acc,
   output kind_type         kind
);

   logic over_range;

   assign over_range = flags[FLAG_FIRST_DASH] ? (acc > LIMIT_NEG) : (acc > LIMIT_POS);

   always_comb begin
      if (flags[FLAG_ALL_LOWER]) begin
         kind = KIND_WORD;
      end else if (len_two_up && flags[FLAG_FIRST_LT] && last_char == CHAR_GT &&
                   flags[FLAG_MID_LOWER]) begin
         kind = KIND_ANGLE;
      end else if (flags[FLAG_NUM_OK] && !(flags[FLAG_FIRST_DASH] && len_one)) begin
         kind = over_range ? KIND_BAD : KIND_NUMBER;
      end else if (len_two_up && flags[FLAG_FIRST_DASH] && flags[FLAG_TAIL_LOWER]) begin
         kind = KIND_OPTION;
      end else if (len_one && last_char == CHAR_COMMA) begin
         kind = KIND_COMMA;
      end else if (len_three_up && flags[FLAG_FIRST_QUOTE] && last_char == CHAR_QUOTE) begin
         kind = KIND_TEXT;
      end else begin
         kind = KIND_BAD;
      end
   end

endmodule

// ===== hdl/cltc_scan.sv =====
module cltc_scan
   import cltc_pkg::*;
#(
   parameter int MAX_LINE = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_stall,
   input  logic [7:0] in_char,
   input  logic       in_eol,
   input  logic       room,
   output push_type   push
);

   localparam int POS_W = $clog2(MAX_LINE + 1);
   localparam int OFF_W = (POS_W > 9) ? POS_W : 9;
   localparam int MUL_W = ACC_W + 4;

   // byte stage
   logic             item_valid_ff, item_valid_in;
   logic [7:0]       item_char_ff;
   logic             item_eol_ff;

   // line and piece state
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] start_ff, start_in;
   logic [POS_W-1:0] len_ff, len_in;
   flags_type        flags_ff, flags_in;
   kind_type         pkind_ff, pkind_in;
   logic [ACC_W-1:0] pacc_ff, pacc_in;
   logic [7:0]       last_ff, last_in;
   logic             quote_ff, quote_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             discard_ff, discard_in;

   logic             accept, advance;
   logic [7:0]       c;
   logic             eol;
   logic             is_low, is_dig, last_low;
   logic [3:0]       digit;
   logic [MUL_W-1:0] acc_x10;
   logic             in_range, closing, do_add;
   kind_type         pre_kind;

   flags_type        a_flags;
   logic [ACC_W-1:0] a_acc, a_pacc;
   kind_type         a_pkind;
   logic [POS_W-1:0] a_start, a_len;
   logic             a_quote;

   flags_type        p_flags;
   logic [ACC_W-1:0] p_acc, p_pacc;
   kind_type         p_pkind;
   logic [POS_W-1:0] p_start, p_len;
   logic [7:0]       p_last;
   kind_type         fin_kind;

   logic             have_piece, split, neg;
   kind_type         kind;
   logic [ACC_W-1:0] tok_acc;
   logic [POS_W-1:0] clen;
   logic [OFF_W-1:0] off_start, off_clen, off_comma;
   result_type       r0, r1;
   logic [1:0]       count;

   assign accept   = in_valid && !in_stall;
   assign advance  = item_valid_ff && room;
   assign in_stall = item_valid_ff && !room;

   assign c        = item_char_ff;
   assign eol      = item_eol_ff;
   assign is_low   = c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z;
   assign is_dig   = c >= CHAR_ZERO && c <= CHAR_NINE;
   assign last_low = last_ff >= CHAR_LOWER_A && last_ff <= CHAR_LOWER_Z;
   assign digit    = 4'(c - CHAR_ZERO);
   assign acc_x10  = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) + MUL_W'(digit);

   assign in_range = pos_ff < POS_W'(MAX_LINE);
   assign closing  = in_range && c == CHAR_SPACE && !quote_ff;
   assign do_add   = in_range && !closing;

   // class of the piece before this byte, kept for a trailing comma split
   cltc_classify u_pre (
      .flags        (flags_ff),
      .len_one      (len_ff == POS_W'(1)),
      .len_two_up   (len_ff >= POS_W'(2)),
      .len_three_up (len_ff > POS_W'(2)),
      .last_char    (last_ff),
      .acc          (acc_ff),
      .kind         (pre_kind)
   );

   always_comb begin
      a_flags = flags_ff;
      a_acc   = acc_ff;
      a_pkind = pre_kind;
      a_pacc  = acc_ff;
      a_start = start_ff;
      if (len_ff == '0) begin
         a_flags                   = '0;
         a_flags[FLAG_TAIL_LOWER]  = 1'b1;
         a_flags[FLAG_MID_LOWER]   = 1'b1;
         a_flags[FLAG_ALL_LOWER]   = is_low;
         a_flags[FLAG_FIRST_LT]    = c == CHAR_LT;
         a_flags[FLAG_NUM_OK]      = c == CHAR_DASH || is_dig;
         a_flags[FLAG_FIRST_DASH]  = c == CHAR_DASH;
         a_flags[FLAG_FIRST_QUOTE] = c == CHAR_QUOTE;
         a_acc   = is_dig ? ACC_W'(digit) : '0;
         a_pkind = KIND_BAD;
         a_pacc  = '0;
         a_start = pos_ff;
      end else begin
         if (!is_low) begin
            a_flags[FLAG_ALL_LOWER]  = 1'b0;
            a_flags[FLAG_TAIL_LOWER] = 1'b0;
         end
         if (len_ff >= POS_W'(2) && !last_low) begin
            a_flags[FLAG_MID_LOWER] = 1'b0;
         end
         if (!is_dig) begin
            a_flags[FLAG_NUM_OK] = 1'b0;
         end
         if (a_flags[FLAG_NUM_OK]) begin
            a_acc = (acc_x10 > {4'b0, ACC_CAP}) ? ACC_CAP : ACC_W'(acc_x10);
         end
      end
      a_len   = len_ff + 1'b1;
      a_quote = a_flags[FLAG_FIRST_QUOTE] && !(len_ff != '0 && c == CHAR_QUOTE);
   end

   // piece as it stands after this byte
   always_comb begin
      if (do_add) begin
         p_flags = a_flags;
         p_acc   = a_acc;
         p_pacc  = a_pacc;
         p_pkind = a_pkind;
         p_start = a_start;
         p_len   = a_len;
         p_last  = c;
      end else begin
         p_flags = flags_ff;
         p_acc   = acc_ff;
         p_pacc  = pacc_ff;
         p_pkind = pkind_ff;
         p_start = start_ff;
         p_len   = len_ff;
         p_last  = last_ff;
      end
   end

   cltc_classify u_fin (
      .flags        (p_flags),
      .len_one      (p_len == POS_W'(1)),
      .len_two_up   (p_len >= POS_W'(2)),
      .len_three_up (p_len > POS_W'(2)),
      .last_char    (p_last),
      .acc          (p_acc),
      .kind         (fin_kind)
   );

   assign have_piece = p_len != '0;
   assign split      = p_len != POS_W'(1) && p_last == CHAR_COMMA;
   assign neg        = p_flags[FLAG_FIRST_DASH];
   assign kind       = split ? p_pkind : fin_kind;
   assign tok_acc    = split ? p_pacc : p_acc;
   assign clen       = split ? p_len - 1'b1 : p_len;
   assign off_comma  = OFF_W'(p_start) + OFF_W'(p_len) - 1'b1;

   always_comb begin
      case (kind)
         KIND_OPTION: begin
            off_start = OFF_W'(p_start) + 1'b1;
            off_clen  = OFF_W'(clen) - 1'b1;
         end
         KIND_ANGLE, KIND_TEXT: begin
            off_start = OFF_W'(p_start) + 1'b1;
            off_clen  = OFF_W'(clen) - 2'd2;
         end
         default: begin
            off_start = OFF_W'(p_start);
            off_clen  = OFF_W'(clen);
         end
      endcase
   end

   always_comb begin
      if (have_piece) begin
         r0.kind   = kind;
         r0.start  = off_start[7:0];
         r0.length = off_clen[8:0];
         r0.value  = '0;
         if (kind == KIND_NUMBER) begin
            r0.value = neg ? 32'(32'd0 - tok_acc[31:0]) : tok_acc[31:0];
         end
         r0.last   = kind == KIND_BAD || (eol && !split);
      end else begin
         r0.kind   = KIND_EMPTY;
         r0.start  = '0;
         r0.length = '0;
         r0.value  = '0;
         r0.last   = 1'b1;
      end
      r1.kind   = KIND_COMMA;
      r1.start  = off_comma[7:0];
      r1.length = 9'd1;
      r1.value  = '0;
      r1.last   = eol;

      count = 2'd0;
      if (advance && !discard_ff && (closing || eol)) begin
         if (!have_piece) begin
            count = eol ? 2'd1 : 2'd0;
         end else if (kind == KIND_BAD || !split) begin
            count = 2'd1;
         end else begin
            count = 2'd2;
         end
      end
      push.count  = count;
      push.first  = r0;
      push.second = r1;
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      if (accept) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
   end

   always_comb begin
      pos_in     = pos_ff;
      start_in   = start_ff;
      len_in     = len_ff;
      flags_in   = flags_ff;
      pkind_in   = pkind_ff;
      pacc_in    = pacc_ff;
      last_in    = last_ff;
      quote_in   = quote_ff;
      acc_in     = acc_ff;
      discard_in = discard_ff;
      if (advance) begin
         if (eol || discard_ff) begin
            if (eol) begin
               // end of line: clear everything
               pos_in     = '0;
               start_in   = '0;
               len_in     = '0;
               flags_in   = '1;
               pkind_in   = KIND_BAD;
               pacc_in    = '0;
               last_in    = '0;
               quote_in   = 1'b0;
               acc_in     = '0;
               discard_in = 1'b0;
            end
         end else begin
            if (in_range) begin
               pos_in = pos_ff + 1'b1;
            end
            if (closing) begin
               len_in   = '0;
               flags_in = '1;
               pkind_in = KIND_BAD;
               pacc_in  = '0;
               last_in  = '0;
               quote_in = 1'b0;
               acc_in   = '0;
               if (have_piece && kind == KIND_BAD) begin
                  discard_in = 1'b1;
               end
            end else if (do_add) begin
               start_in = a_start;
               len_in   = a_len;
               flags_in = a_flags;
               pkind_in = a_pkind;
               pacc_in  = a_pacc;
               last_in  = c;
               quote_in = a_quote;
               acc_in   = a_acc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         pos_ff        <= '0;
         start_ff      <= '0;
         len_ff        <= '0;
         flags_ff      <= '1;
         pkind_ff      <= KIND_BAD;
         pacc_ff       <= '0;
         last_ff       <= '0;
         quote_ff      <= 1'b0;
         acc_ff        <= '0;
         discard_ff    <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         pos_ff        <= pos_in;
         start_ff      <= start_in;
         len_ff        <= len_in;
         flags_ff      <= flags_in;
         pkind_ff      <= pkind_in;
         pacc_ff       <= pacc_in;
         last_ff       <= last_in;
         quote_ff      <= quote_in;
         acc_ff        <= acc_in;
         discard_ff    <= discard_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_char_ff <= in_char;
         item_eol_ff  <= in_eol;
      end
   end

endmodule

// ===== hdl/cltc_outq.sv =====
module cltc_outq
   import cltc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       room,
   output logic       out_valid,
   input  logic       out_stall,
   output result_type out_word
);

   result_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic [QPTR_W-1:0]   wr_next;
   logic                pop;

   assign room      = cnt_ff <= QCNT_W'(QUEUE_DEPTH - 2);
   assign out_valid = cnt_ff != '0;
   assign out_word  = entry_ff[rd_ff];
   assign pop       = out_valid && !out_stall;
   assign wr_next   = wr_ff + 1'b1;

   always_comb begin
      wr_in  = wr_ff + QPTR_W'(push.count);
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(push.count) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

endmodule

// ===== hdl/command_line_token_classifier.sv =====
// channel  direction  handshake            payload
// req      in         req_valid/req_stall  char_code, end_of_line
// rsp      out        rsp_valid/rsp_stall  token_kind, content_start, content_length,
//                                          number_value, last
//
// One byte is taken per cycle while req_stall is low; a byte is held in the
// byte register, then its result words go to the buffer and from there to rsp.
// A byte gives zero, one or two result words; they queue in a four-word buffer.
// req_stall rises while the buffer cannot take two more words and a byte waits.
// Reset clears the line state and empties the buffer; no clearing pass is needed.
module command_line_token_classifier
   import cltc_pkg::*;
#(
   parameter int MAX_LINE = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_char_code,
   input  logic               req_end_of_line,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_token_kind,
   output logic [7:0]         rsp_content_start,
   output logic [8:0]         rsp_content_length,
   output logic signed [31:0] rsp_number_value,
   output logic               rsp_last
);

   push_type   push;
   logic       room;
   result_type head;

   cltc_scan #(
      .MAX_LINE (MAX_LINE)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_stall (req_stall),
      .in_char  (req_char_code),
      .in_eol   (req_end_of_line),
      .room     (room),
      .push     (push)
   );

   cltc_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (head)
   );

   assign rsp_token_kind     = head.kind;
   assign rsp_content_start  = head.start;
   assign rsp_content_length = head.length;
   assign rsp_number_value   = head.value;
   assign rsp_last           = head.last;

endmodule
